/* hw/rtl/scs_pkg.sv */
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants for the speech chunk segmenter: register
// indexes, reset values, descriptor causes and the descriptor record.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int MS_W        = 16;
	localparam int CHUNK_W     = 24;
	localparam int OUT_DATA_W  = 32;

	// register indexes on the configuration channel
	localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_LIMIT      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_CHUNK        = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PREROLL_LEN      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HISTORY_CAPACITY = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_PAUSE_MS         = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_MS         = 3'd5;

	// register reset values
	localparam logic [CFG_DATA_W-1:0] RST_CHUNK_LIMIT      = 24'd240000;
	localparam logic [CFG_DATA_W-1:0] RST_MIN_CHUNK        = 24'd16000;
	localparam logic [CFG_DATA_W-1:0] RST_PREROLL_LEN      = 24'd8000;
	localparam logic [CFG_DATA_W-1:0] RST_HISTORY_CAPACITY = 24'd160000;
	localparam logic [MS_W-1:0]       RST_PAUSE_MS         = 16'd1500;
	localparam logic [MS_W-1:0]       RST_SLEEP_MS         = 16'd15000;

	// input word kinds
	localparam logic ACT_FRAME = 1'b0;
	localparam logic ACT_WAKE  = 1'b1;

	// descriptor causes
	localparam logic [1:0] CAUSE_SLEEP     = 2'd0;
	localparam logic [1:0] CAUSE_PAUSE_SIL = 2'd1;
	localparam logic [1:0] CAUSE_PAUSE_END = 2'd2;
	localparam logic [1:0] CAUSE_FULL      = 2'd3;

	typedef struct packed {
		logic [CHUNK_W-1:0] chunk_length;
		logic [1:0]         cause;
		logic               last;
		logic               listening;
	} desc_t;

endpackage

`default_nettype wire

/* hw/rtl/speech_chunk_segmenter.sv */
// ----------------------------------------------------------------------------
// speech_chunk_segmenter
// Tracks wake and silence state over audio frames and wake messages and
// emits chunk descriptors (length, cause) into a small output queue.
// ----------------------------------------------------------------------------
// An accepted word is registered and decided once the queue has room for two
//   descriptors; its descriptors then go through the output queue to the master side.
// Throughput: one input word per cycle while the queue has room for two
//   descriptors; the master side moves one descriptor per cycle while m_tready is high.
// Reset: arst_n clears all tracking state and the queue at once; the
//   registers return to their documented defaults.
`default_nettype none

module speech_chunk_segmenter #(
	parameter int COUNT_BITS = 24,
	parameter int TIME_BITS  = 32,
	parameter int FRAME_BITS = 12
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	// cfg
	input  wire logic                                       cfg_valid,
	output logic                                            cfg_ready,
	input  wire logic [scs_pkg::CFG_INDEX_W-1:0]            cfg_index,
	input  wire logic [scs_pkg::CFG_DATA_W-1:0]             cfg_data,
	// slave side
	input  wire logic                                       s_tvalid,
	output logic                                            s_tready,
	// tdata: frame_length, voice_present, time_ms, wake_value, zero pad
	input  wire logic [((FRAME_BITS+TIME_BITS+2+7)/8)*8-1:0] s_tdata,
	// tuser: action
	input  wire logic                                       s_tuser,
	// master side
	output logic                                            m_tvalid,
	input  wire logic                                       m_tready,
	// tdata: chunk_length, listening, zero pad
	output logic [scs_pkg::OUT_DATA_W-1:0]                  m_tdata,
	// tuser: cause
	output logic [1:0]                                      m_tuser,
	output logic                                            m_tlast
);

	import scs_pkg::*;

	localparam int CW = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
	localparam int SW = ((COUNT_BITS > FRAME_BITS) ? COUNT_BITS : FRAME_BITS) + 1;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// configuration registers
	logic [CFG_DATA_W-1:0] chunk_limit_q, min_chunk_q, preroll_len_q, history_capacity_q;
	logic [MS_W-1:0]       pause_ms_q, sleep_ms_q;

	// tracking state
	logic                  awake_q, in_silence_q;
	logic [TIME_BITS-1:0]  silence_start_q, silence_total_q;
	logic [COUNT_BITS-1:0] pending_count_q, history_fill_q;

	// input register
	logic                  valid_s1, action_s1, voice_s1, wake_s1;
	logic [FRAME_BITS-1:0] flen_s1;
	logic [TIME_BITS-1:0]  time_s1;

	// output queue
	desc_t               fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	logic fire_s1, pop, cfg_wr;

	// next-state logic
	logic                  awake_n, in_silence_n;
	logic [TIME_BITS-1:0]  silence_start_n, silence_total_n;
	logic [COUNT_BITS-1:0] pending_n, history_fill_n;
	logic [COUNT_BITS-1:0] pend_w, pend_sum, take, fill_sat;
	logic [SW-1:0]         fill_wide, pend_wide;
	logic [COUNT_BITS:0]   wake_wide;
	logic [TIME_BITS:0]    total_wide;
	logic [TIME_BITS-1:0]  diff, diff2;
	logic                  cont;
	logic                  a_v, b_v;
	logic [CHUNK_W-1:0]    a_len, b_len;
	logic [1:0]            a_cause, b_cause;
	desc_t                 e0, e1;
	logic [1:0]            n_push;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	// a word is decided only when the queue has room for two descriptors
	assign fire_s1  = valid_s1 && (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign s_tready = !valid_s1 || fire_s1;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			flen_s1   <= s_tdata[FRAME_BITS-1:0];
			voice_s1  <= s_tdata[FRAME_BITS];
			time_s1   <= s_tdata[FRAME_BITS+TIME_BITS:FRAME_BITS+1];
			wake_s1   <= s_tdata[FRAME_BITS+TIME_BITS+1];
		end
	end

	always_comb begin
		awake_n         = awake_q;
		in_silence_n    = in_silence_q;
		silence_start_n = silence_start_q;
		silence_total_n = silence_total_q;
		pending_n       = pending_count_q;
		history_fill_n  = history_fill_q;
		pend_w          = pending_count_q;
		pend_sum        = pending_count_q;
		pend_wide       = '0;
		diff2           = '0;
		cont            = 1'b0;
		a_v             = 1'b0;
		b_v             = 1'b0;
		a_len           = '0;
		b_len           = '0;
		a_cause         = CAUSE_SLEEP;
		b_cause         = CAUSE_FULL;
		diff            = time_s1 - silence_start_q;
		total_wide      = {1'b0, silence_total_q} + {1'b0, diff};

		take = (CW'(preroll_len_q) < CW'(history_fill_q))
			? COUNT_BITS'(preroll_len_q) : history_fill_q;
		wake_wide = {1'b0, pending_count_q} + {1'b0, take};

		fill_wide = SW'(history_fill_q) + SW'(flen_s1);
		fill_sat  = (fill_wide[SW-1:COUNT_BITS] != '0)
			? '1 : fill_wide[COUNT_BITS-1:0];

		if (fire_s1) begin
			if (action_s1 == ACT_WAKE) begin
				if (wake_s1 && !awake_q) begin
					awake_n   = 1'b1;
					pending_n = wake_wide[COUNT_BITS] ? '1 : wake_wide[COUNT_BITS-1:0];
				end
			end else begin
				history_fill_n = (CW'(fill_sat) > CW'(history_capacity_q))
					? COUNT_BITS'(history_capacity_q) : fill_sat;
				cont = awake_q;
				if (!voice_s1) begin
					if (!awake_q) begin
						cont = 1'b0;
					end else if (!in_silence_q) begin
						in_silence_n    = 1'b1;
						silence_start_n = time_s1;
						cont            = 1'b0;
					end else begin
						silence_total_n = total_wide[TIME_BITS] ? '1 : total_wide[TIME_BITS-1:0];
						silence_start_n = time_s1;
						if (silence_total_n >= TIME_BITS'(sleep_ms_q)) begin
							// long silence: go to sleep and flush everything
							awake_n         = 1'b0;
							in_silence_n    = 1'b0;
							silence_total_n = '0;
							a_v             = (pend_w != '0);
							a_len           = CHUNK_W'(pend_w);
							a_cause         = CAUSE_SLEEP;
							pend_w          = '0;
							cont            = 1'b0;
						end else if (silence_total_n >= TIME_BITS'(pause_ms_q) &&
							CW'(pend_w) >= CW'(min_chunk_q)) begin
							a_v     = (pend_w != '0);
							a_len   = CHUNK_W'(pend_w);
							a_cause = CAUSE_PAUSE_SIL;
							pend_w  = '0;
						end
					end
				end else if (in_silence_q) begin
					in_silence_n    = 1'b0;
					silence_total_n = '0;
				end

				pend_wide = SW'(pend_w) + SW'(flen_s1);
				pend_sum  = (pend_wide[SW-1:COUNT_BITS] != '0)
					? '1 : pend_wide[COUNT_BITS-1:0];
				diff2     = time_s1 - silence_start_n;
				if (cont) begin
					if (in_silence_n && diff2 >= TIME_BITS'(pause_ms_q)) begin
						if (CW'(pend_sum) >= CW'(min_chunk_q)) begin
							b_v      = (pend_sum != '0);
							b_len    = CHUNK_W'(pend_sum);
							b_cause  = CAUSE_PAUSE_END;
							pend_sum = '0;
						end
						in_silence_n = 1'b0;
					end else if (chunk_limit_q != '0 &&
						CW'(pend_sum) >= CW'(chunk_limit_q)) begin
						b_v      = 1'b1;
						b_len    = CHUNK_W'(chunk_limit_q);
						b_cause  = CAUSE_FULL;
						pend_sum = pend_sum - COUNT_BITS'(chunk_limit_q);
					end
					pend_w = pend_sum;
				end
				pending_n = pend_w;
			end
		end

		// capacity write trims the history fill
		if (cfg_wr && cfg_index == REG_HISTORY_CAPACITY &&
			CW'(history_fill_n) > CW'(cfg_data)) begin
			history_fill_n = COUNT_BITS'(cfg_data);
		end

		n_push = {1'b0, a_v} + {1'b0, b_v};

		e0.chunk_length = a_v ? a_len : b_len;
		e0.cause        = a_v ? a_cause : b_cause;
		e0.last         = (n_push == 2'd1);
		e0.listening    = awake_n;
		e1.chunk_length = b_len;
		e1.cause        = b_cause;
		e1.last         = 1'b1;
		e1.listening    = awake_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awake_q         <= 1'b0;
			in_silence_q    <= 1'b0;
			silence_start_q <= '0;
			silence_total_q <= '0;
			pending_count_q <= '0;
			history_fill_q  <= '0;
		end else begin
			awake_q         <= awake_n;
			in_silence_q    <= in_silence_n;
			silence_start_q <= silence_start_n;
			silence_total_q <= silence_total_n;
			pending_count_q <= pending_n;
			history_fill_q  <= history_fill_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_limit_q      <= RST_CHUNK_LIMIT;
			min_chunk_q        <= RST_MIN_CHUNK;
			preroll_len_q      <= RST_PREROLL_LEN;
			history_capacity_q <= RST_HISTORY_CAPACITY;
			pause_ms_q         <= RST_PAUSE_MS;
			sleep_ms_q         <= RST_SLEEP_MS;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_CHUNK_LIMIT:      chunk_limit_q      <= cfg_data;
				REG_MIN_CHUNK:        min_chunk_q        <= cfg_data;
				REG_PREROLL_LEN:      preroll_len_q      <= cfg_data;
				REG_HISTORY_CAPACITY: history_capacity_q <= cfg_data;
				REG_PAUSE_MS:         pause_ms_q         <= cfg_data[MS_W-1:0];
				REG_SLEEP_MS:         sleep_ms_q         <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// output queue
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			fifo_q[wr_ptr_q] <= e0;
		end
		if (n_push == 2'd2) begin
			fifo_q[wr_ptr_q + QPTR_W'(1)] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_push);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			cnt_q    <= cnt_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = OUT_DATA_W'({fifo_q[rd_ptr_q].listening, fifo_q[rd_ptr_q].chunk_length});
	assign m_tuser  = fifo_q[rd_ptr_q].cause;
	assign m_tlast  = fifo_q[rd_ptr_q].last;

`ifndef SYNTHESIS
	a_fill_capped: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(history_fill_q) <= CW'(history_capacity_q))
		else $error("history fill above capacity");

	a_asleep_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!awake_q |-> (!in_silence_q && silence_total_q == '0))
		else $error("silence tracked while asleep");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("output queue overrun");

	a_word_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !m_tlast) |=> m_tvalid)
		else $error("descriptor missing after a non-final one");

	a_sleep_not_listening: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == CAUSE_SLEEP) |-> !fifo_q[rd_ptr_q].listening)
		else $error("sleep descriptor marked listening");
`endif

endmodule

`default_nettype wire

/* tb/tb_speech_chunk_segmenter.sv */
// ----------------------------------------------------------------------------
// tb_speech_chunk_segmenter
// Self-checking bench for the speech chunk segmenter. Audio frames and wake
// messages go in on the slave stream, and an internal tracker of the wake,
// silence, pending and history state works out the chunk descriptors due.
// Descriptors on the master stream are checked against those in order. Two
// hand-built sequences run first, then a long voiced run with no chunk limit
// and full-scale count and pause settings, then loose random words and wake
// sessions under several settings. Both streams idle and stall at random.
// ----------------------------------------------------------------------------

module tb_speech_chunk_segmenter;
	import scs_pkg::*;

	localparam int FRAME_W       = 12;
	localparam int TIME_W        = 32;
	localparam int IN_DATA_W     = ((FRAME_W + TIME_W + 2 + 7) / 8) * 8;
	localparam int CYCLE_LIMIT   = 1200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 140;
	localparam int FILL_FRAMES   = 250;

	localparam logic [CFG_INDEX_W-1:0] REG_BEYOND = REG_SLEEP_MS + 1'b1;
	localparam logic [CHUNK_W-1:0]     COUNT_MAX  = '1;
	localparam logic [MS_W-1:0]        MS_MAX     = '1;
	localparam logic [FRAME_W-1:0]     FRAME_MAX  = '1;

	typedef struct packed {
		logic               action;
		logic [FRAME_W-1:0] frame_length;
		logic               voice;
		logic [TIME_W-1:0]  time_ms;
		logic               wake_value;
	} seg_word_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	// tdata: frame_length, voice_present, time_ms, wake_value, zero pad
	logic [IN_DATA_W-1:0]   s_tdata   = '0;
	// tuser: action
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b1;
	// tdata: chunk_length, listening, zero pad
	logic [OUT_DATA_W-1:0]  m_tdata;
	// tuser: cause
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	speech_chunk_segmenter dut (.*);

	always #5 clk = ~clk;

	// tracked copy of the registers and the segmenter state
	logic [CHUNK_W-1:0] lim_cfg     = RST_CHUNK_LIMIT;
	logic [CHUNK_W-1:0] min_cfg     = RST_MIN_CHUNK;
	logic [CHUNK_W-1:0] preroll_cfg = RST_PREROLL_LEN;
	logic [CHUNK_W-1:0] cap_cfg     = RST_HISTORY_CAPACITY;
	logic [MS_W-1:0]    pause_cfg   = RST_PAUSE_MS;
	logic [MS_W-1:0]    sleep_cfg   = RST_SLEEP_MS;
	logic               awake_m     = 1'b0;
	logic               quiet_m     = 1'b0;
	logic [TIME_W-1:0]  quiet_since = '0;
	logic [TIME_W-1:0]  quiet_total = '0;
	logic [CHUNK_W-1:0] pending_m   = '0;
	logic [CHUNK_W-1:0] history_m   = '0;

	desc_t     chunk_burst[$];
	desc_t     desc_expected[$];
	seg_word_t word_plan[$];
	seg_word_t in_flight;

	logic [TIME_W-1:0] clock_ms = '0;
	int words_planned = 0;
	int words_taken   = 0;
	int descs_seen    = 0;
	int regs_written  = 0;
	int error_count   = 0;
	int cause_tally[4] = '{default: 0};
	int in_gap   = 0;
	int in_calm  = 0;
	int out_wait = 0;
	int out_calm = 0;
	int cycles   = 0;

	function automatic logic [CHUNK_W-1:0] add_count(logic [CHUNK_W-1:0] a, logic [CHUNK_W-1:0] b);
		logic [CHUNK_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CHUNK_W] ? COUNT_MAX : sum[CHUNK_W-1:0];
	endfunction

	function void emit_chunk(logic [CHUNK_W-1:0] len, logic [1:0] cause);
		desc_t d;
		d.chunk_length = len;
		d.cause        = cause;
		d.last         = 1'b0;
		d.listening    = 1'b0;
		if (chunk_burst.size() < 2)
			chunk_burst.push_back(d);
	endfunction

	function void flush_pending(logic [1:0] cause);
		if (pending_m != '0)
			emit_chunk(pending_m, cause);
		pending_m = '0;
	endfunction

	function void frame_update(seg_word_t w);
		logic [TIME_W:0]   grown;
		logic [TIME_W-1:0] since;
		history_m = add_count(history_m, CHUNK_W'(w.frame_length));
		if (history_m > cap_cfg)
			history_m = cap_cfg;
		if (!w.voice) begin
			if (!awake_m)
				return;
			if (!quiet_m) begin
				quiet_m = 1'b1;
				quiet_since = w.time_ms;
				return;
			end
			since = w.time_ms - quiet_since;
			grown = {1'b0, quiet_total} + {1'b0, since};
			quiet_total = grown[TIME_W] ? '1 : grown[TIME_W-1:0];
			quiet_since = w.time_ms;
			if (quiet_total >= TIME_W'(sleep_cfg)) begin
				awake_m = 1'b0;
				quiet_m = 1'b0;
				quiet_total = '0;
				flush_pending(CAUSE_SLEEP);
				return;
			end
			if (quiet_total >= TIME_W'(pause_cfg) && pending_m >= min_cfg)
				flush_pending(CAUSE_PAUSE_SIL);
		end else if (quiet_m) begin
			quiet_m = 1'b0;
			quiet_total = '0;
		end
		if (!awake_m)
			return;
		pending_m = add_count(pending_m, CHUNK_W'(w.frame_length));
		since = w.time_ms - quiet_since;
		if (quiet_m && since >= TIME_W'(pause_cfg)) begin
			if (pending_m >= min_cfg)
				flush_pending(CAUSE_PAUSE_END);
			quiet_m = 1'b0;
		end else if (lim_cfg != '0 && pending_m >= lim_cfg) begin
			emit_chunk(lim_cfg, CAUSE_FULL);
			pending_m = pending_m - lim_cfg;
		end
	endfunction

	// descriptors due for one accepted word, appended in order
	function void forecast_descriptors(seg_word_t w);
		logic [CHUNK_W-1:0] take;
		chunk_burst.delete();
		if (w.action == ACT_WAKE) begin
			if (w.wake_value && !awake_m) begin
				take = (preroll_cfg < history_m) ? preroll_cfg : history_m;
				awake_m = 1'b1;
				pending_m = add_count(pending_m, take);
			end
		end else begin
			frame_update(w);
		end
		foreach (chunk_burst[k]) begin
			chunk_burst[k].last      = (k == chunk_burst.size() - 1);
			chunk_burst[k].listening = awake_m;
			desc_expected.push_back(chunk_burst[k]);
		end
	endfunction

	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(10, 60);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function void note_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	function void plan_word(logic action, logic [FRAME_W-1:0] len, logic voice,
			logic [TIME_W-1:0] at, logic wake);
		seg_word_t w;
		w.action       = action;
		w.frame_length = len;
		w.voice        = voice;
		w.time_ms      = at;
		w.wake_value   = wake;
		word_plan.push_back(w);
		words_planned++;
	endfunction

	function void plan_frame_after(int step, logic [FRAME_W-1:0] len, logic voice);
		clock_ms = clock_ms + TIME_W'(step);
		plan_word(ACT_FRAME, len, voice, clock_ms, 1'($urandom));
	endfunction

	// wake, then voiced and silent runs with plausible timing
	function void plan_session(int frames);
		int  run_left;
		int  span;
		logic voiced;
		span = int'(pause_cfg) / 3 + 2;
		if ($urandom_range(0, 7) == 0)
			plan_word(ACT_WAKE, FRAME_W'($urandom), 1'($urandom), $urandom, 1'b0);
		plan_word(ACT_WAKE, FRAME_W'($urandom), 1'($urandom), $urandom, 1'b1);
		if ($urandom_range(0, 7) == 0)
			plan_word(ACT_WAKE, FRAME_W'($urandom), 1'($urandom), $urandom, 1'b1);
		voiced = 1'b1;
		run_left = $urandom_range(1, 8);
		for (int i = 0; i < frames; i++) begin
			if (run_left == 0) begin
				voiced = !voiced;
				run_left = voiced ? $urandom_range(1, 8) : $urandom_range(1, 25);
			end
			run_left--;
			if ($urandom_range(0, 39) == 0)
				plan_frame_after($urandom, FRAME_W'($urandom), voiced);
			else
				plan_frame_after($urandom_range(0, span), FRAME_W'($urandom), voiced);
		end
		// trailing silence often long enough to put the block to sleep
		if ($urandom_range(0, 1) == 0)
			for (int i = 0; i < 30; i++)
				plan_frame_after($urandom_range(0, span), FRAME_W'($urandom), 1'b0);
	endfunction

	// driver
	always @(posedge clk) begin : drive
		logic [IN_DATA_W-1:0] packed_word;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				forecast_descriptors(in_flight);
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_tvalid <= 1'b0;
				end else if (word_plan.size() != 0) begin
					in_flight = word_plan.pop_front();
					packed_word = '0;
					packed_word[FRAME_W-1:0]                    = in_flight.frame_length;
					packed_word[FRAME_W]                        = in_flight.voice;
					packed_word[FRAME_W+1 +: TIME_W]            = in_flight.time_ms;
					packed_word[FRAME_W+TIME_W+1]               = in_flight.wake_value;
					s_tdata  <= packed_word;
					s_tuser  <= in_flight.action;
					s_tvalid <= 1'b1;
					in_gap = draw_wait(in_calm);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		desc_t seen;
		desc_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.chunk_length = m_tdata[CHUNK_W-1:0];
				seen.listening    = m_tdata[CHUNK_W];
				seen.cause        = m_tuser;
				seen.last         = m_tlast;
				descs_seen++;
				cause_tally[m_tuser]++;
				if (desc_expected.size() == 0) begin
					note_error($sformatf("unexpected word len %0d cause %0d last %0b listening %0b",
						seen.chunk_length, seen.cause, seen.last, seen.listening));
				end else begin
					want = desc_expected.pop_front();
					if (seen !== want)
						note_error($sformatf({"len %0d/%0d cause %0d/%0d last %0b/%0b ",
							"listening %0b/%0b (expected/actual)"},
							want.chunk_length, seen.chunk_length, want.cause, seen.cause,
							want.last, seen.last, want.listening, seen.listening));
				end
				out_wait = draw_wait(out_calm);
				m_tready <= (out_wait == 0);
			end else if (!m_tready) begin
				if (out_wait > 0)
					out_wait--;
				m_tready <= (out_wait == 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d words taken, %0d descriptors due",
				cycles, words_taken, words_planned, desc_expected.size());
			$display("tb_speech_chunk_segmenter: errors");
			$finish;
		end
	end

	// all planned words taken, all descriptors seen, then the pipeline drained
	task automatic settle();
		while (words_taken != words_planned || desc_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high so back-to-back writes keep the channel busy
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_CHUNK_LIMIT:  lim_cfg = val;
			REG_MIN_CHUNK:    min_cfg = val;
			REG_PREROLL_LEN:  preroll_cfg = val;
			REG_HISTORY_CAPACITY: begin
				cap_cfg = val;
				if (history_m > cap_cfg)
					history_m = cap_cfg;
			end
			REG_PAUSE_MS:     pause_cfg = val[MS_W-1:0];
			REG_SLEEP_MS:     sleep_cfg = val[MS_W-1:0];
			default: ;
		endcase
		regs_written++;
	endtask

	task automatic write_settings(input logic [CHUNK_W-1:0] lim, input logic [CHUNK_W-1:0] mn,
			input logic [CHUNK_W-1:0] pre, input logic [CHUNK_W-1:0] cap,
			input logic [MS_W-1:0] pz, input logic [MS_W-1:0] slp);
		logic [CFG_DATA_W-1:0] reg_word;
		settle();
		write_reg(REG_CHUNK_LIMIT, lim);
		write_reg(REG_MIN_CHUNK, mn);
		write_reg(REG_PREROLL_LEN, pre);
		write_reg(REG_HISTORY_CAPACITY, cap);
		// upper bits of the millisecond registers are don't-care
		reg_word = CFG_DATA_W'($urandom);
		reg_word[MS_W-1:0] = pz;
		write_reg(REG_PAUSE_MS, reg_word);
		reg_word = CFG_DATA_W'($urandom);
		reg_word[MS_W-1:0] = slp;
		write_reg(REG_SLEEP_MS, reg_word);
		write_reg(CFG_INDEX_W'($urandom_range(REG_BEYOND, (1 << CFG_INDEX_W) - 1)),
			CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [MS_W-1:0] pz;
		int mark;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-built sequence, time crossing the wrap point
		write_settings(24'd5000, 24'd100, 24'd3000, 24'd6000, 16'd100, 16'd400);
		clock_ms = 32'hFFFF_FF80;
		plan_frame_after(20, FRAME_MAX, 1'b1);
		plan_frame_after(20, '0, 1'b0);
		plan_word(ACT_WAKE, '0, 1'b0, '0, 1'b0);
		plan_word(ACT_WAKE, FRAME_MAX, 1'b1, '1, 1'b1);
		plan_word(ACT_WAKE, '0, 1'b0, '0, 1'b1);
		plan_frame_after(20, FRAME_MAX, 1'b1);
		plan_frame_after(20, 12'd10, 1'b0);
		plan_frame_after(150, 12'd10, 1'b0);
		plan_frame_after(20, 12'd100, 1'b1);
		plan_frame_after(10, '0, 1'b0);
		plan_frame_after(300, 12'd77, 1'b0);
		plan_frame_after(200, 12'd50, 1'b0);
		plan_frame_after(20, FRAME_MAX, 1'b1);

		// zero pause lets both pause checks fire on one frame
		write_settings(24'd5000, 24'd100, 24'd3000, 24'd6000, '0, 16'd400);
		plan_word(ACT_WAKE, '0, 1'b0, '0, 1'b1);
		plan_frame_after(5, '0, 1'b0);
		plan_frame_after(5, 12'd100, 1'b0);
		plan_frame_after(10, 12'd500, 1'b1);
		plan_frame_after(5, '0, 1'b0);
		plan_frame_after(10, 12'd200, 1'b0);
		plan_frame_after(5, '0, 1'b0);
		// backward step: the silence total saturates
		plan_frame_after(-1, 12'd9, 1'b0);

		// long voiced run, no chunk limit, full-scale count and pause settings
		write_settings('0, COUNT_MAX, COUNT_MAX, COUNT_MAX, MS_MAX, 16'd1);
		plan_word(ACT_WAKE, '0, 1'b0, '0, 1'b1);
		for (int i = 0; i < FILL_FRAMES; i++)
			plan_frame_after(1, FRAME_MAX, 1'b1);
		plan_frame_after(1, '0, 1'b0);
		plan_frame_after(2, '0, 1'b0);
		plan_word(ACT_WAKE, '0, 1'b0, '0, 1'b1);
		plan_frame_after(1, FRAME_MAX, 1'b1);
		plan_frame_after(1, '0, 1'b0);
		plan_frame_after(1, '0, 1'b0);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: write_settings(COUNT_MAX, '0, COUNT_MAX, COUNT_MAX, MS_MAX, MS_MAX);
				2: write_settings(24'd1, COUNT_MAX, 24'd1, 24'd1, 16'd1, '0);
				3: write_settings('0, '0, '0, '0, '0, MS_W'($urandom_range(50, 300)));
				default: begin
					pz = MS_W'($urandom_range(20, 400));
					write_settings(CHUNK_W'($urandom_range(2000, 20000)),
						CHUNK_W'($urandom_range(0, 6000)),
						CHUNK_W'($urandom_range(0, 12000)), CHUNK_W'($urandom_range(1, 40000)),
						pz, MS_W'(pz * $urandom_range(1, 6)));
				end
			endcase
			clock_ms = $urandom;
			mark = words_planned;
			while (words_planned - mark < PHASE_WORDS) begin
				if ($urandom_range(0, 9) < 2) begin
					repeat ($urandom_range(1, 8))
						plan_word(1'($urandom), FRAME_W'($urandom), 1'($urandom), $urandom,
							1'($urandom));
				end else begin
					plan_session($urandom_range(5, 60));
				end
			end
		end

		settle();
		$display("summary: %0d words in, %0d register writes, %0d descriptors out",
			words_taken, regs_written, descs_seen);
		$display("summary: causes sleep %0d, silence pause %0d, end pause %0d, full %0d; %0d mismatches",
			cause_tally[CAUSE_SLEEP], cause_tally[CAUSE_PAUSE_SIL],
			cause_tally[CAUSE_PAUSE_END], cause_tally[CAUSE_FULL], error_count);
		if (error_count == 0)
			$display("tb_speech_chunk_segmenter: clean");
		else
			$display("tb_speech_chunk_segmenter: errors");
		$finish;
	end

endmodule
